### hdl/rpm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RMS power monitor with overload trip.
// Used by every module under hdl; depends on nothing.
package rpm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MAX_WINDOW  = 1024;
    localparam int WIN_BITS    = 11;
    localparam int SUM_BITS    = 33;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS   = 17;
    localparam int GAIN_BITS   = 24;
    localparam int PROD_BITS   = ROOT_BITS + GAIN_BITS;
    localparam int CUR_BITS    = 16;
    localparam int VOLT_BITS   = 9;
    localparam int PWR_BITS    = 25;
    localparam int CFG_BITS    = 25;
    localparam int IDX_BITS    = 3;

    localparam logic [IDX_BITS-1:0] CFG_MIDPOINT = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_WINDOW   = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_GAIN     = 3'd2;
    localparam logic [IDX_BITS-1:0] CFG_FLOOR    = 3'd3;
    localparam logic [IDX_BITS-1:0] CFG_VOLTS    = 3'd4;
    localparam logic [IDX_BITS-1:0] CFG_LIMIT    = 3'd5;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_BUTTON  = 2'd1,
        KIND_COMMAND = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [SQ_BITS-1:0]   square;
        logic                 command_on;
    } entry_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_midpoint;
        logic [WIN_BITS-1:0]    window_samples;
        logic [GAIN_BITS-1:0]   current_gain_q16;
        logic [CUR_BITS-1:0]    noise_floor_ma;
        logic [VOLT_BITS-1:0]   mains_volts;
        logic [PWR_BITS-1:0]    power_limit_mw;
    } cfg_t;

    typedef struct packed {
        logic                relay_on;
        logic                measure_valid;
        logic [CUR_BITS-1:0] current_ma;
        logic [PWR_BITS-1:0] power_mw;
        logic                overload_trip;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### hdl/rms_power_monitor_overload_trip_unit.sv
`timescale 1ns / 1ps
// RMS current and power monitor with overload trip relay, top level.
// Depends on rpm_pkg, rpm_front, rpm_queue and rpm_back.
//
// Input items arrive on s_tvalid/s_tready: s_tuser carries the mode (sensor
// sample, button press, network command), s_tdata the sample and the command.
// Every item yields one result item on m_tvalid/m_tready: relay state, and for
// the sample that closes a window the RMS current, the power and the trip flag
// (measurement valid flag in m_tuser).
// A two-entry queue lies between the front end and the back end, so the front
// end keeps taking items while a result waits for the receiver.
// A plain item passes the queue slot and the result register; a window-closing
// sample also goes through the 33-step divider, the 17-step square root unit and
// the multiply, scale, power and finish states. The back end handles one item at a
// time: one plain item a cycle while m_tready is high, none while a window closes.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while idle, which the block does not enforce.
// Indexes above 5 are dropped. Reset clears the accumulator, sample count, queue
// and output valid flag, opens the relay and loads default settings. While
// m_tready is low the result holds and, once the queue fills, s_tready drops.
module rms_power_monitor_overload_trip_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpm_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [rpm_pkg::CFG_BITS-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [11:0] sample, [12] command_on
    input  logic [1:0]                     s_tuser,   // [1:0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // [0] relay_on, [16:1] current_ma,
                                                      // [41:17] power_mw, [42] overload_trip
    output logic                           m_tuser    // [0] measure_valid
);

    rpm_pkg::cfg_t          cfg_reg;
    rpm_pkg::cfg_t          cfg_next;
    rpm_pkg::queue_status_t queue_status;
    rpm_pkg::entry_t        push_entry;
    rpm_pkg::entry_t        pop_entry;
    rpm_pkg::result_t       result;
    logic                   push;
    logic                   pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rpm_pkg::CFG_MIDPOINT:
                    cfg_next.sample_midpoint  = cfg_wdata[rpm_pkg::SAMPLE_BITS-1:0];
                rpm_pkg::CFG_WINDOW:
                    cfg_next.window_samples   = cfg_wdata[rpm_pkg::WIN_BITS-1:0];
                rpm_pkg::CFG_GAIN:
                    cfg_next.current_gain_q16 = cfg_wdata[rpm_pkg::GAIN_BITS-1:0];
                rpm_pkg::CFG_FLOOR:
                    cfg_next.noise_floor_ma   = cfg_wdata[rpm_pkg::CUR_BITS-1:0];
                rpm_pkg::CFG_VOLTS:
                    cfg_next.mains_volts      = cfg_wdata[rpm_pkg::VOLT_BITS-1:0];
                rpm_pkg::CFG_LIMIT:
                    cfg_next.power_limit_mw   = cfg_wdata[rpm_pkg::PWR_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_midpoint  <= 12'd2047;
            cfg_reg.window_samples   <= 11'd100;
            cfg_reg.current_gain_q16 <= 24'd570950;
            cfg_reg.noise_floor_ma   <= 16'd50;
            cfg_reg.mains_volts      <= 9'd230;
            cfg_reg.power_limit_mw   <= 25'd2500000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rpm_front u_front (
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .mode            (s_tuser),
        .sample          (s_tdata[rpm_pkg::SAMPLE_BITS-1:0]),
        .command_on      (s_tdata[rpm_pkg::SAMPLE_BITS]),
        .sample_midpoint (cfg_reg.sample_midpoint),
        .queue_status    (queue_status),
        .push            (push),
        .entry           (push_entry)
    );

    rpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (queue_status)
    );

    rpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_status (queue_status),
        .entry        (pop_entry),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result       (result)
    );

    assign m_tdata = {5'd0, result.overload_trip, result.power_mw,
                      result.current_ma, result.relay_on};
    assign m_tuser = result.measure_valid;

endmodule

### hdl/rpm_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items, classifies them and squares the sample deviation.
// Depends on rpm_pkg.
module rpm_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [1:0]                         mode,
    input  logic [rpm_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic                               command_on,
    input  logic [rpm_pkg::SAMPLE_BITS-1:0]    sample_midpoint,
    input  rpm_pkg::queue_status_t             queue_status,
    output logic                               push,
    output rpm_pkg::entry_t                    entry
);

    logic [rpm_pkg::SAMPLE_BITS-1:0] dev;

    always_comb
    begin
        if (sample >= sample_midpoint)
        begin
            dev = sample - sample_midpoint;
        end
        else
        begin
            dev = sample_midpoint - sample;
        end
        entry.kind       = rpm_pkg::kind_t'(mode);
        entry.square     = rpm_pkg::SQ_BITS'(dev) * rpm_pkg::SQ_BITS'(dev);
        entry.command_on = command_on;
    end

    assign s_tready = !queue_status.full;
    assign push     = s_tvalid && !queue_status.full;

endmodule

### hdl/rpm_queue.sv
`timescale 1ns / 1ps
// Two-entry item queue between the front end and the back end.
// Depends on rpm_pkg.
module rpm_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rpm_pkg::entry_t        push_entry,
    input  logic                   pop,
    output rpm_pkg::entry_t        pop_entry,
    output rpm_pkg::queue_status_t status
);

    rpm_pkg::entry_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry    = slot_reg[rd_ptr_reg];
    assign status.full  = count_reg[1];
    assign status.empty = (count_reg == 2'd0);

endmodule

### hdl/rpm_back.sv
`timescale 1ns / 1ps
// Back end: accumulates squares, runs divide, square root, scaling and trip logic.
// Holds the result register. Depends on rpm_pkg.
module rpm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpm_pkg::cfg_t          cfg,
    input  rpm_pkg::queue_status_t queue_status,
    input  rpm_pkg::entry_t        entry,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rpm_pkg::result_t       result
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_SQRT  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_POW   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    localparam int RAD_BITS  = 2 * rpm_pkg::ROOT_BITS;
    localparam int SREM_BITS = rpm_pkg::ROOT_BITS + 3;
    localparam logic [rpm_pkg::WIN_BITS-1:0] WIN_MAX =
        rpm_pkg::WIN_BITS'(rpm_pkg::MAX_WINDOW);

    state_t                           state_reg, state_next;
    logic                             out_valid_reg, out_valid_next;
    rpm_pkg::result_t                 result_reg, result_next;
    logic [rpm_pkg::SUM_BITS-1:0]     sum_reg, sum_next;
    logic [rpm_pkg::WIN_BITS-1:0]     cnt_reg, cnt_next;
    logic                             relay_reg, relay_next;
    logic [rpm_pkg::WIN_BITS-1:0]     win_reg, win_next;
    logic [rpm_pkg::SUM_BITS-1:0]     quo_reg, quo_next;
    logic [rpm_pkg::WIN_BITS:0]       rem_reg, rem_next;
    logic [5:0]                       step_reg, step_next;
    logic [RAD_BITS-1:0]              rad_reg, rad_next;
    logic [rpm_pkg::ROOT_BITS-1:0]    root_reg, root_next;
    logic [SREM_BITS-1:0]             srem_reg, srem_next;
    logic [rpm_pkg::PROD_BITS-1:0]    prod_reg, prod_next;
    logic [rpm_pkg::CUR_BITS-1:0]     cur_reg, cur_next;
    logic [rpm_pkg::PWR_BITS-1:0]     pwr_reg, pwr_next;

    logic                             out_free;
    logic [rpm_pkg::WIN_BITS-1:0]     win_eff;
    logic [rpm_pkg::WIN_BITS-1:0]     cnt_inc;
    logic [rpm_pkg::SUM_BITS:0]       sum_add;
    logic [rpm_pkg::SUM_BITS-1:0]     sum_sat;
    logic [rpm_pkg::WIN_BITS:0]       div_trial;
    logic [SREM_BITS-1:0]             sqrt_acc;
    logic [SREM_BITS-1:0]             sqrt_trial;
    logic [rpm_pkg::PWR_BITS-1:0]     cur_wide;
    logic [rpm_pkg::CUR_BITS-1:0]     cur_sat;
    logic                             trip;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;

        if (cfg.window_samples == '0)
        begin
            win_eff = rpm_pkg::WIN_BITS'(1);
        end
        else if (cfg.window_samples > WIN_MAX)
        begin
            win_eff = WIN_MAX;
        end
        else
        begin
            win_eff = cfg.window_samples;
        end

        cnt_inc = cnt_reg + rpm_pkg::WIN_BITS'(1);
        sum_add = {1'b0, sum_reg} + (rpm_pkg::SUM_BITS + 1)'(entry.square);
        sum_sat = sum_add[rpm_pkg::SUM_BITS] ? '1 : sum_add[rpm_pkg::SUM_BITS-1:0];

        div_trial  = {rem_reg[rpm_pkg::WIN_BITS-1:0], quo_reg[rpm_pkg::SUM_BITS-1]};
        sqrt_acc   = {srem_reg[SREM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
        sqrt_trial = {1'b0, root_reg, 2'b01};

        cur_wide = prod_reg[rpm_pkg::PROD_BITS-1:16];
        cur_sat  = (|cur_wide[rpm_pkg::PWR_BITS-1:rpm_pkg::CUR_BITS]) ? '1
                 : cur_wide[rpm_pkg::CUR_BITS-1:0];
        trip     = (pwr_reg > cfg.power_limit_mw) && relay_reg;

        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        relay_next     = relay_reg;
        win_next       = win_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;
        pwr_next       = pwr_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_status.empty && out_free)
                begin
                    pop = 1'b1;
                    result_next = '0;
                    case (entry.kind)
                        rpm_pkg::KIND_SAMPLE:
                        begin
                            if (cnt_inc >= win_eff)
                            begin
                                sum_next   = '0;
                                cnt_next   = '0;
                                win_next   = win_eff;
                                quo_next   = sum_sat;
                                rem_next   = '0;
                                step_next  = '0;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                sum_next       = sum_sat;
                                cnt_next       = cnt_inc;
                                out_valid_next = 1'b1;
                                result_next.relay_on = relay_reg;
                            end
                        end
                        rpm_pkg::KIND_BUTTON:
                        begin
                            relay_next           = !relay_reg;
                            out_valid_next       = 1'b1;
                            result_next.relay_on = !relay_reg;
                        end
                        rpm_pkg::KIND_COMMAND:
                        begin
                            relay_next           = entry.command_on;
                            out_valid_next       = 1'b1;
                            result_next.relay_on = entry.command_on;
                        end
                        default:
                        begin
                            out_valid_next       = 1'b1;
                            result_next.relay_on = relay_reg;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_trial >= {1'b0, win_reg})
                begin
                    rem_next = div_trial - {1'b0, win_reg};
                    quo_next = {quo_reg[rpm_pkg::SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_trial;
                    quo_next = {quo_reg[rpm_pkg::SUM_BITS-2:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(rpm_pkg::SUM_BITS - 1))
                begin
                    rad_next   = {1'b0, quo_next};
                    root_next  = '0;
                    srem_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_acc >= sqrt_trial)
                begin
                    srem_next = sqrt_acc - sqrt_trial;
                    root_next = {root_reg[rpm_pkg::ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    srem_next = sqrt_acc;
                    root_next = {root_reg[rpm_pkg::ROOT_BITS-2:0], 1'b0};
                end
                rad_next  = {rad_reg[RAD_BITS-3:0], 2'b00};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(rpm_pkg::ROOT_BITS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = rpm_pkg::PROD_BITS'(root_reg)
                           * rpm_pkg::PROD_BITS'(cfg.current_gain_q16);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cur_next   = (cur_sat < cfg.noise_floor_ma) ? '0 : cur_sat;
                state_next = ST_POW;
            end
            ST_POW:
            begin
                pwr_next   = rpm_pkg::PWR_BITS'(cfg.mains_volts)
                           * rpm_pkg::PWR_BITS'(cur_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    relay_next                = relay_reg && !trip;
                    out_valid_next            = 1'b1;
                    result_next.relay_on      = relay_reg && !trip;
                    result_next.measure_valid = 1'b1;
                    result_next.current_ma    = cur_reg;
                    result_next.power_mw      = pwr_reg;
                    result_next.overload_trip = trip;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            relay_reg     <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            relay_reg     <= relay_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        win_reg    <= win_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        prod_reg   <= prod_next;
        cur_reg    <= cur_next;
        pwr_reg    <= pwr_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

### tb/sv/rms_power_monitor_overload_trip_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rms_power_monitor_overload_trip_unit: directed and random
// sample, button and command items checked against an in-bench meter model.
// Depends on rpm_pkg and the unit under test; needs no files or arguments.
module rms_power_monitor_overload_trip_unit_test;

    import rpm_pkg::*;

    localparam longint unsigned SUM_CEIL     = (64'd1 << SUM_BITS) - 1;
    localparam longint unsigned CURRENT_CEIL = (64'd1 << CUR_BITS) - 1;
    localparam longint unsigned POWER_CEIL   = (64'd1 << PWR_BITS) - 1;
    localparam longint unsigned GAIN_CEIL    = (64'd1 << GAIN_BITS) - 1;
    localparam longint unsigned UNITY_GAIN   = 64'd65536;
    localparam logic [IDX_BITS-1:0] CFG_SPARE = 3'd7;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_ITEMS    = 420;
    localparam int CALM_ITEMS      = 150;
    localparam int SAT_ITEMS       = 560;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = '1;
    localparam int WINDOW_TOP      = (1 << WIN_BITS) - 1;
    localparam int FLOOR_TOP       = (1 << CUR_BITS) - 1;
    localparam int VOLTS_TOP       = (1 << VOLT_BITS) - 1;

    localparam cfg_t RESET_SETTINGS = '{
        sample_midpoint:  12'd2047,
        window_samples:   11'd100,
        current_gain_q16: 24'd570950,
        noise_floor_ma:   16'd50,
        mains_volts:      9'd230,
        power_limit_mw:   25'd2500000
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [47:0]         m_tdata;
    logic                m_tuser;

    cfg_t                settings     = RESET_SETTINGS;
    longint unsigned     acc_sum      = 0;
    logic [WIN_BITS-1:0] acc_count    = '0;
    logic                relay_closed = 1'b0;
    result_t             due_results[$];

    int  errors       = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    int  stall_left   = 0;
    bit  idle_on      = 1'b1;

    rms_power_monitor_overload_trip_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = ROOT_BITS - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic result_t meter_result_for(kind_t mode, logic [SAMPLE_BITS-1:0] smp,
                                                 logic cmd);
        result_t         r;
        longint unsigned dev;
        longint unsigned win;
        longint unsigned cur;
        longint unsigned pwr;
        r = '0;
        if (mode == KIND_SAMPLE)
        begin
            dev = (smp >= settings.sample_midpoint) ? smp - settings.sample_midpoint
                                                    : settings.sample_midpoint - smp;
            win = settings.window_samples;
            if (win == 0)
                win = 1;
            if (win > MAX_WINDOW)
                win = MAX_WINDOW;
            acc_sum = acc_sum + dev * dev;
            if (acc_sum > SUM_CEIL)
                acc_sum = SUM_CEIL;
            acc_count = acc_count + 1'b1;
            if (acc_count >= win)
            begin
                cur = (root_floor(acc_sum / win) * settings.current_gain_q16) >> 16;
                if (cur > CURRENT_CEIL)
                    cur = CURRENT_CEIL;
                if (cur < settings.noise_floor_ma)
                    cur = 0;
                pwr = settings.mains_volts * cur;
                if (pwr > POWER_CEIL)
                    pwr = POWER_CEIL;
                r.measure_valid = 1'b1;
                r.current_ma    = cur[CUR_BITS-1:0];
                r.power_mw      = pwr[PWR_BITS-1:0];
                if (pwr > settings.power_limit_mw && relay_closed)
                begin
                    relay_closed    = 1'b0;
                    r.overload_trip = 1'b1;
                end
                acc_sum   = 0;
                acc_count = '0;
            end
        end
        else if (mode == KIND_BUTTON)
            relay_closed = !relay_closed;
        else if (mode == KIND_COMMAND)
            relay_closed = cmd;
        r.relay_on = relay_closed;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SAMPLE_TOP;
            default: return SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP));
        endcase
    endfunction

    function automatic longint unsigned pick(longint unsigned lo_ext, longint unsigned hi_ext,
                                             int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 9))
            0: return lo_ext;
            1: return hi_ext;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Drop valid, let every expected item come back, then leave a short gap.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_setting(logic [IDX_BITS-1:0] idx, longint unsigned value);
        logic [CFG_BITS-1:0] v;
        v = value[CFG_BITS-1:0];
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_MIDPOINT: settings.sample_midpoint  = v[SAMPLE_BITS-1:0];
            CFG_WINDOW:   settings.window_samples   = v[WIN_BITS-1:0];
            CFG_GAIN:     settings.current_gain_q16 = v[GAIN_BITS-1:0];
            CFG_FLOOR:    settings.noise_floor_ma   = v[CUR_BITS-1:0];
            CFG_VOLTS:    settings.mains_volts      = v[VOLT_BITS-1:0];
            CFG_LIMIT:    settings.power_limit_mw   = v[PWR_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_item(kind_t mode, logic [SAMPLE_BITS-1:0] smp, logic cmd);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, cmd, smp};
        do
            @(posedge clk);
        while (!s_tready);
        due_results.push_back(meter_result_for(mode, smp, cmd));
    endtask

    task automatic offer_random_item();
        int    roll;
        kind_t mode;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            mode = KIND_SAMPLE;
        else if (roll < 89)
            mode = KIND_BUTTON;
        else if (roll < 98)
            mode = KIND_COMMAND;
        else
            mode = KIND_NONE;
        offer_item(mode, random_sample(), $urandom_range(0, 9) < 7);
    endtask

    task automatic test_relay_control();
        offer_item(KIND_BUTTON, 12'd0, 1'b0);
        offer_item(KIND_BUTTON, SAMPLE_TOP, 1'b1);
        offer_item(KIND_BUTTON, 12'd0, 1'b0);
        offer_item(KIND_COMMAND, 12'd0, 1'b0);
        offer_item(KIND_COMMAND, SAMPLE_TOP, 1'b1);
        offer_item(KIND_NONE, SAMPLE_TOP, 1'b0);
        offer_item(KIND_SAMPLE, 12'd2047, 1'b1);
    endtask

    task automatic test_measure_extremes();
        write_setting(CFG_WINDOW, 0);
        write_setting(CFG_MIDPOINT, 0);
        write_setting(CFG_GAIN, UNITY_GAIN);
        write_setting(CFG_FLOOR, 0);
        write_setting(CFG_VOLTS, 10);
        write_setting(CFG_LIMIT, POWER_CEIL);
        write_setting(CFG_SPARE, 12345);
        offer_item(KIND_SAMPLE, 12'd0, 1'b0);
        offer_item(KIND_SAMPLE, SAMPLE_TOP, 1'b0);
        offer_item(KIND_SAMPLE, 12'd100, 1'b0);
        write_setting(CFG_MIDPOINT, SAMPLE_TOP);
        offer_item(KIND_SAMPLE, 12'd0, 1'b0);
        offer_item(KIND_SAMPLE, SAMPLE_TOP, 1'b0);
        write_setting(CFG_GAIN, GAIN_CEIL);
        write_setting(CFG_VOLTS, VOLTS_TOP);
        offer_item(KIND_SAMPLE, 12'd0, 1'b0);
        write_setting(CFG_GAIN, 0);
        offer_item(KIND_SAMPLE, 12'd0, 1'b0);
    endtask

    task automatic test_noise_floor();
        write_setting(CFG_WINDOW, 1);
        write_setting(CFG_MIDPOINT, 0);
        write_setting(CFG_GAIN, UNITY_GAIN);
        write_setting(CFG_VOLTS, 10);
        write_setting(CFG_FLOOR, 101);
        offer_item(KIND_SAMPLE, 12'd100, 1'b0);
        write_setting(CFG_FLOOR, 100);
        offer_item(KIND_SAMPLE, 12'd100, 1'b0);
        write_setting(CFG_FLOOR, FLOOR_TOP);
        offer_item(KIND_SAMPLE, SAMPLE_TOP, 1'b0);
    endtask

    task automatic test_trip_threshold();
        write_setting(CFG_FLOOR, 0);
        write_setting(CFG_LIMIT, 1000);
        offer_item(KIND_COMMAND, 12'd0, 1'b1);
        offer_item(KIND_SAMPLE, 12'd100, 1'b0);
        write_setting(CFG_LIMIT, 999);
        offer_item(KIND_SAMPLE, 12'd100, 1'b0);
        offer_item(KIND_SAMPLE, 12'd100, 1'b0);
    endtask

    task automatic test_window_shrink();
        write_setting(CFG_WINDOW, 10);
        repeat (4) offer_item(KIND_SAMPLE, random_sample(), 1'b0);
        write_setting(CFG_WINDOW, 3);
        offer_item(KIND_SAMPLE, random_sample(), 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_left = HOLD_CYCLES;
        repeat (16) offer_random_item();
        wait_idle();
    endtask

    task automatic test_accumulator_saturation();
        write_setting(CFG_WINDOW, WINDOW_TOP);
        write_setting(CFG_MIDPOINT, 0);
        write_setting(CFG_GAIN, UNITY_GAIN);
        write_setting(CFG_FLOOR, 0);
        write_setting(CFG_VOLTS, 1);
        write_setting(CFG_LIMIT, POWER_CEIL);
        for (int i = 0; i < SAT_ITEMS - 1; i++)
            offer_item(KIND_SAMPLE, (i % 50 == 7) ? random_sample() : SAMPLE_TOP, 1'b0);
        write_setting(CFG_WINDOW, SAT_ITEMS);
        offer_item(KIND_SAMPLE, SAMPLE_TOP, 1'b0);
    endtask

    task automatic test_random_traffic();
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1)) write_setting(CFG_MIDPOINT, pick(0, SAMPLE_TOP, 1900, 2200));
            if ($urandom_range(0, 1)) write_setting(CFG_WINDOW, pick(0, 1, 2, 12));
            if ($urandom_range(0, 1)) write_setting(CFG_GAIN, pick(0, GAIN_CEIL, 200000, 900000));
            if ($urandom_range(0, 1)) write_setting(CFG_FLOOR, pick(0, FLOOR_TOP, 0, 3000));
            if ($urandom_range(0, 1)) write_setting(CFG_VOLTS, pick(0, VOLTS_TOP, 100, 260));
            if ($urandom_range(0, 1)) write_setting(CFG_LIMIT, pick(0, POWER_CEIL, 0, 3000000));
            idle_on = (sent < RANDOM_ITEMS - CALM_ITEMS);
            n = $urandom_range(30, 90);
            repeat (n) offer_random_item();
            sent += n;
        end
    endtask

    // Result side: random stalls, plus the long hold-off when one is pending.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
            begin
                $error("result item with no expectation waiting");
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("relay_on", want.relay_on, m_tdata[0]);
                check_field("measure_valid", want.measure_valid, m_tuser);
                check_field("current_ma", want.current_ma, m_tdata[16:1]);
                check_field("power_mw", want.power_mw, m_tdata[41:17]);
                check_field("overload_trip", want.overload_trip, m_tdata[42]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_relay_control();
        test_measure_extremes();
        test_noise_floor();
        test_trip_threshold();
        test_window_shrink();
        test_backpressure();
        test_accumulator_saturation();
        test_random_traffic();
        wait_idle();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/rpm_pkg.sv
hdl/rpm_front.sv
hdl/rpm_queue.sv
hdl/rpm_back.sv
hdl/rms_power_monitor_overload_trip_unit.sv
tb/sv/rms_power_monitor_overload_trip_unit_test.sv
